[rtl/camera_smooth_approach_defines.svh]
// assertion macros for the camera block checkers
`ifndef CAMERA_SMOOTH_APPROACH_DEFINES_SVH
`define CAMERA_SMOOTH_APPROACH_DEFINES_SVH

// same-cycle implication
`define CSA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("camera_smooth_approach check failed");

// next-cycle implication
`define CSA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("camera_smooth_approach check failed");

`endif

[rtl/csa_pkg.sv]
package csa_pkg;

	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_TARGET = 2'd1;
	localparam logic [1:0] OP_EFFECT = 2'd2;

	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MAX_X = 3'd1;
	localparam logic [2:0] REG_MIN_Y = 3'd2;
	localparam logic [2:0] REG_MAX_Y = 3'd3;
	localparam logic [2:0] REG_MIN_Z = 3'd4;
	localparam logic [2:0] REG_MAX_Z = 3'd5;

	localparam int US_BITS  = 20;
	localparam int DEN_BITS = 22;
	localparam logic [31:0] BOUND_LO_RST = 32'h8000_0000;
	localparam logic [31:0] BOUND_HI_RST = 32'h7FFF_FFFF;

	typedef struct packed {
		logic       load;
		logic       div_start;
		logic       div_sel;
		logic       m_load;
		logic       rate_set;
		logic       rate_div;
		logic       mul_en;
		logic [3:0] step;
		logic       clamp;
		logic       snap;
		logic       finish;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic op_tick;
		logic us_zero;
		logic m_zero;
		logic div_done;
	} sts_t;

endpackage

[rtl/camera_smooth_approach.sv]
// channel | signals                                   | accepted when
// in      | in_valid, in_ready, op .. end_z            | in_valid && in_ready
// out     | out_valid, out_ready, cam_*_out .. phase_out | out_valid && out_ready
// cfg     | cfg_we, cfg_idx, cfg_data                  | cfg_we
// Op 1, 2 and 3 words pass only through the accept and the result load.
// A tick with elapsed_us of 0 skips the divider; otherwise two radix-2 divider
// passes of NW quotient bits each (NW = max(20, FRAC_BITS+3), 20 at Q16.16)
// and one check state come first, with only the first pass when m is 0. Then
// the 12-step multiply sequence runs, four steps per axis, then clamp, snap, finish.
// Reset zeroes camera, target and phase and opens the bounds; waypoints are not reset.
// A new word is taken while the last result still waits on out_ready.
module camera_smooth_approach #(
	parameter int FRAC_BITS  = 16,
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_idx,
	input  logic [31:0]                  cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   op,
	input  logic [19:0]                  elapsed_us,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic signed [COORD_BITS-1:0] end_z,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] cam_x_out,
	output logic signed [COORD_BITS-1:0] cam_y_out,
	output logic signed [COORD_BITS-1:0] cam_z_out,
	output logic                         bounced,
	output logic                         arrived,
	output logic [2:0]                   phase_out
);
	import csa_pkg::*;

	cmd_t cmd;
	sts_t sts;

	csa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	csa_dp #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.op         (op),
		.elapsed_us (elapsed_us),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.end_x      (end_x),
		.end_y      (end_y),
		.end_z      (end_z),
		.cam_x_out  (cam_x_out),
		.cam_y_out  (cam_y_out),
		.cam_z_out  (cam_z_out),
		.bounced    (bounced),
		.arrived    (arrived),
		.phase_out  (phase_out)
	);
endmodule

[rtl/csa_div.sv]
module csa_div #(
	parameter int NW = 20,
	parameter int DW = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CNTW = $clog2(NW + 1);

	logic [DW-1:0]   rem_q;
	logic [DW-1:0]   den_q;
	logic [NW-1:0]   sh_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     trial;
	logic            ge;

	assign trial = {rem_q, sh_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign done  = done_q;
	assign quo   = sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			rem_q <= '0;
			den_q <= den;
			sh_q  <= num;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(trial - {1'b0, den_q}) : DW'(trial);
			sh_q  <= {sh_q[NW-2:0], ge};
		end
	end
endmodule

[rtl/csa_dp.sv]
module csa_dp #(
	parameter int FRAC_BITS  = 16,
	parameter int COORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  csa_pkg::cmd_t                cmd,
	output csa_pkg::sts_t                sts,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_idx,
	input  logic [31:0]                  cfg_data,
	input  logic [1:0]                   op,
	input  logic [19:0]                  elapsed_us,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	input  logic signed [COORD_BITS-1:0] end_z,
	output logic signed [COORD_BITS-1:0] cam_x_out,
	output logic signed [COORD_BITS-1:0] cam_y_out,
	output logic signed [COORD_BITS-1:0] cam_z_out,
	output logic                         bounced,
	output logic                         arrived,
	output logic [2:0]                   phase_out
);
	import csa_pkg::*;

	localparam int F  = FRAC_BITS;
	localparam int CW = COORD_BITS;
	localparam int NW = (F + 3 > US_BITS) ? F + 3 : US_BITS;
	localparam int MW = (CW - F > F) ? CW - F : F;
	localparam logic [F:0]    ONE_Q    = (F+1)'(1) << F;
	localparam logic [F:0]    RATE_Z   = (F+1)'((5 * (2 ** F)) / 21);
	localparam logic [NW-1:0] NUM_MEGA = NW'(1000000);
	localparam logic [NW-1:0] NUM_FAST = NW'(5 * (2 ** F));
	localparam logic [CW-1:0] SNAP_MAX = CW'((2 ** F - 1) / 200);

	logic [31:0] min_q [3];
	logic [31:0] max_q [3];
	logic signed [CW-1:0] cam_q [3];
	logic signed [CW-1:0] tgt_q [3];
	logic signed [CW-1:0] st_q  [3];
	logic signed [CW-1:0] en_q  [3];
	logic [2:0]           phase_q;
	logic                 was_q;
	logic                 bnc_q;
	logic [US_BITS-1:0]   us_q;
	logic [US_BITS-1:0]   m_q;
	logic [F:0]           r_q;
	logic [CW-1:0]        gap_q;
	logic                 up_q;
	logic [MW+F:0]        ph_q;
	logic [MW+F:0]        pl_q;

	logic signed [CW-1:0] lo [3];
	logic signed [CW-1:0] hi [3];
	logic signed [CW-1:0] nt [3];
	logic signed [CW-1:0] c_sel;
	logic signed [CW-1:0] t_sel;
	logic [1:0]           ax;
	logic [MW-1:0]        mop;
	logic [MW+F:0]        prod;
	logic [MW+F:0]        sum;
	logic [CW-1:0]        sc;
	logic                 slow;
	logic                 match;
	logic [2:0]           phase_nx;
	logic                 div_done;
	logic [NW-1:0]        quo;
	logic [NW-1:0]        div_num;
	logic [DEN_BITS-1:0]  div_den;
	logic [DEN_BITS-1:0]  m2;
	logic [DEN_BITS-1:0]  m3;

	assign ax    = cmd.step[3:2];
	assign c_sel = cam_q[ax];
	assign t_sel = tgt_q[ax];
	assign mop   = cmd.step[1:0] == 2'd1 ? MW'(gap_q[CW-1:F]) : MW'(gap_q[F-1:0]);
	assign prod  = (MW+F+1)'(mop * r_q);
	assign sum   = ph_q + (pl_q >> F);
	assign sc    = CW'(sum);
	assign slow  = phase_q >= 3'd2;
	assign match = cam_q[0] == tgt_q[0] && cam_q[1] == tgt_q[1] && cam_q[2] == tgt_q[2];

	assign m2      = {1'b0, m_q, 1'b0};
	assign m3      = m2 + {2'b0, m_q};
	assign div_num = cmd.div_sel ? (slow ? NW'(ONE_Q) : NUM_FAST) : NUM_MEGA;
	assign div_den = cmd.div_sel ? (slow ? m3 : m2) : {2'b0, us_q};

	assign sts.op_tick  = op == OP_TICK;
	assign sts.us_zero  = us_q == '0;
	assign sts.m_zero   = m_q == '0;
	assign sts.div_done = div_done;

	csa_div #(.NW(NW), .DW(DEN_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (quo)
	);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			lo[a] = CW'($signed(min_q[a]));
			hi[a] = CW'($signed(max_q[a]));
			case (phase_q)
				3'd1:    nt[a] = st_q[a];
				3'd3:    nt[a] = en_q[a];
				default: nt[a] = tgt_q[a];
			endcase
		end
		case (phase_q)
			3'd0:    phase_nx = 3'd0;
			3'd1:    phase_nx = 3'd2;
			3'd2:    phase_nx = was_q ? 3'd3 : 3'd2;
			3'd3:    phase_nx = 3'd4;
			3'd4:    phase_nx = was_q ? 3'd0 : 3'd4;
			default: phase_nx = 3'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				min_q[a] <= BOUND_LO_RST;
				max_q[a] <= BOUND_HI_RST;
				cam_q[a] <= '0;
				tgt_q[a] <= '0;
			end
			phase_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_MIN_X: min_q[0] <= cfg_data;
					REG_MAX_X: max_q[0] <= cfg_data;
					REG_MIN_Y: min_q[1] <= cfg_data;
					REG_MAX_Y: max_q[1] <= cfg_data;
					REG_MIN_Z: min_q[2] <= cfg_data;
					REG_MAX_Z: max_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load) begin
				case (op)
					OP_TARGET: begin
						tgt_q[0] <= pos_x;
						tgt_q[1] <= pos_y;
						tgt_q[2] <= pos_z;
						phase_q  <= 3'd0;
					end
					OP_EFFECT: phase_q <= 3'd1;
					default: ;
				endcase
			end
			if (cmd.mul_en && cmd.step[1:0] == 2'd3)
				cam_q[ax] <= up_q ? c_sel + $signed(sc) : c_sel - $signed(sc);
			if (cmd.clamp) begin
				phase_q <= phase_nx;
				for (int a = 0; a < 3; a++) begin
					if (cam_q[a] < lo[a]) begin
						cam_q[a] <= lo[a];
						tgt_q[a] <= lo[a];
					end else if (cam_q[a] > hi[a]) begin
						cam_q[a] <= hi[a];
						tgt_q[a] <= hi[a];
					end else begin
						tgt_q[a] <= nt[a];
					end
				end
			end
			if (cmd.snap) begin
				for (int a = 0; a < 3; a++) begin
					if ((tgt_q[a] > cam_q[a] ? CW'(tgt_q[a] - cam_q[a])
					     : CW'(cam_q[a] - tgt_q[a])) <= SNAP_MAX)
						cam_q[a] <= tgt_q[a];
				end
			end
			if (cmd.finish && match)
				phase_q <= 3'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			us_q  <= elapsed_us;
			was_q <= match;
			bnc_q <= 1'b0;
			if (op == OP_EFFECT) begin
				st_q[0] <= pos_x;
				st_q[1] <= pos_y;
				st_q[2] <= pos_z;
				en_q[0] <= end_x;
				en_q[1] <= end_y;
				en_q[2] <= end_z;
			end
		end
		if (cmd.m_load)
			m_q <= quo[US_BITS-1:0];
		if (cmd.rate_set)
			r_q <= (sts.us_zero && slow) ? RATE_Z : ONE_Q;
		if (cmd.rate_div)
			r_q <= quo > NW'(ONE_Q) ? ONE_Q : quo[F:0];
		if (cmd.mul_en) begin
			case (cmd.step[1:0])
				2'd0: begin
					up_q  <= t_sel > c_sel;
					gap_q <= t_sel > c_sel ? CW'(t_sel - c_sel) : CW'(c_sel - t_sel);
				end
				2'd1:    ph_q <= prod;
				2'd2:    pl_q <= prod;
				default: ;
			endcase
		end
		if (cmd.clamp) begin
			for (int a = 0; a < 3; a++)
				if (cam_q[a] < lo[a] || cam_q[a] > hi[a])
					bnc_q <= 1'b1;
		end
		if (cmd.out_load) begin
			cam_x_out <= cam_q[0];
			cam_y_out <= cam_q[1];
			cam_z_out <= cam_q[2];
			bounced   <= bnc_q;
			arrived   <= match;
			phase_out <= phase_q;
		end
	end
endmodule

[rtl/csa_ctrl.sv]
module csa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  csa_pkg::sts_t sts,
	output csa_pkg::cmd_t cmd
);
	import csa_pkg::*;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_RATE  = 10'b00_0000_0010,
		S_DIV1  = 10'b00_0000_0100,
		S_MCHK  = 10'b00_0000_1000,
		S_DIV2  = 10'b00_0001_0000,
		S_MUL   = 10'b00_0010_0000,
		S_CLAMP = 10'b00_0100_0000,
		S_SNAP  = 10'b00_1000_0000,
		S_FIN   = 10'b01_0000_0000,
		S_DONE  = 10'b10_0000_0000
	} state_t;

	state_t     state_q, state_nx;
	logic [3:0] step_q;
	logic       ov_q;
	logic       out_free;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = ov_q;
	assign out_free  = !ov_q || out_ready;

	always_comb begin
		cmd      = '0;
		cmd.step = step_q;
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = sts.op_tick ? S_RATE : S_DONE;
				end
			end
			S_RATE: begin
				if (sts.us_zero) begin
					cmd.rate_set = 1'b1;
					state_nx     = S_MUL;
				end else begin
					cmd.div_start = 1'b1;
					state_nx      = S_DIV1;
				end
			end
			S_DIV1: begin
				if (sts.div_done) begin
					cmd.m_load = 1'b1;
					state_nx   = S_MCHK;
				end
			end
			S_MCHK: begin
				if (sts.m_zero) begin
					cmd.rate_set = 1'b1;
					state_nx     = S_MUL;
				end else begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = 1'b1;
					state_nx      = S_DIV2;
				end
			end
			S_DIV2: begin
				if (sts.div_done) begin
					cmd.rate_div = 1'b1;
					state_nx     = S_MUL;
				end
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				if (step_q == 4'd11)
					state_nx = S_CLAMP;
			end
			S_CLAMP: begin
				cmd.clamp = 1'b1;
				state_nx  = S_SNAP;
			end
			S_SNAP: begin
				cmd.snap = 1'b1;
				state_nx = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_nx   = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_nx;
			step_q  <= (state_q == S_MUL) ? step_q + 1'b1 : '0;
			if (cmd.out_load)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end
endmodule

[rtl/csa_chk.sv]
`include "camera_smooth_approach_defines.svh"

module csa_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] phase_out
);
	`CSA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
	`CSA_ASSERT_NEXT(a_one_word, in_valid && in_ready, !in_ready)
	`CSA_ASSERT_NOW(a_phase_rng, out_valid, phase_out <= 3'd4)
	`CSA_ASSERT_NEXT(a_phase_hold, out_valid && !out_ready, $stable(phase_out))
endmodule

bind camera_smooth_approach csa_chk u_csa_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.phase_out (phase_out)
);

[bench/tb_camera_smooth_approach.sv]
module tb_camera_smooth_approach;
	timeunit 1ns;
	timeprecision 1ps;
	import csa_pkg::*;

	localparam int ONE_Q = 65536;
	localparam int WATCH_LIMIT = 4000;
	localparam int SETTLE = 150;

	typedef struct {
		logic signed [31:0] cx, cy, cz;
		logic               bnc, arr;
		logic [2:0]         ph;
	} cam_word_t;

	typedef struct {
		logic [1:0]         op;
		logic [19:0]        us;
		logic signed [31:0] p[3];
		logic signed [31:0] e[3];
		bit                 typed;
		cam_word_t          want;
	} stim_row_t;

	typedef struct {
		bit        typed;
		cam_word_t want;
	} typed_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_idx = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [1:0] op = '0;
	logic [19:0] elapsed_us = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] end_x = '0, end_y = '0, end_z = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] cam_x_out, cam_y_out, cam_z_out;
	logic bounced, arrived;
	logic [2:0] phase_out;

	camera_smooth_approach i_dut (.*);

	always #5 clk = ~clk;

	// shadow state of the camera
	longint cam[3], tgt[3], wp_start[3], wp_end[3];
	logic [31:0] lo_bnd[3], hi_bnd[3];
	int phase;

	cam_word_t cam_q[$];
	typed_t typed_q[$];
	int errors = 0;
	int idle_cycles = 0;
	bit calm = 0;
	bit hold_req = 0;
	bit tx_busy_gap = 0;

	function automatic longint ease_rate(logic [19:0] us);
		longint r, m;
		bit slow;
		slow = phase >= 2;
		if (us == 0) begin
			r = slow ? (ONE_Q * 5) / 21 : ONE_Q;
		end else begin
			m = 1000000 / us;
			if (m == 0) r = ONE_Q;
			else r = slow ? ONE_Q / (3 * m) : (5 * ONE_Q) / (2 * m);
		end
		return r > ONE_Q ? ONE_Q : r;
	endfunction

	function automatic longint scaled_gap(longint g, longint r);
		return (g >>> 16) * r + (((g & 64'hFFFF) * r) >>> 16);
	endfunction

	function automatic bit at_target();
		return cam[0] == tgt[0] && cam[1] == tgt[1] && cam[2] == tgt[2];
	endfunction

	function automatic cam_word_t step_camera(logic [1:0] o, logic [19:0] us,
			logic signed [31:0] p[3], logic signed [31:0] e[3]);
		cam_word_t w;
		longint r, g, l, h;
		bit there, bnc;
		bnc = 0;
		if (o == OP_TICK) begin
			r = ease_rate(us);
			there = at_target();
			for (int a = 0; a < 3; a++) begin
				if (tgt[a] < cam[a]) cam[a] -= scaled_gap(cam[a] - tgt[a], r);
				else if (tgt[a] > cam[a]) cam[a] += scaled_gap(tgt[a] - cam[a], r);
			end
			case (phase)
				0: ;
				1: begin
					tgt = wp_start;
					phase = 2;
				end
				2: if (there) phase = 3;
				3: begin
					tgt = wp_end;
					phase = 4;
				end
				4: if (there) phase = 0;
				default: phase = 0;
			endcase
			for (int a = 0; a < 3; a++) begin
				l = longint'($signed(lo_bnd[a]));
				h = longint'($signed(hi_bnd[a]));
				if (cam[a] < l) begin
					cam[a] = l;
					tgt[a] = l;
					bnc = 1;
				end else if (cam[a] > h) begin
					cam[a] = h;
					tgt[a] = h;
					bnc = 1;
				end
			end
			for (int a = 0; a < 3; a++) begin
				g = tgt[a] > cam[a] ? tgt[a] - cam[a] : cam[a] - tgt[a];
				if (g != 0 && g * 200 < ONE_Q) cam[a] = tgt[a];
			end
			if (at_target()) phase = 0;
		end else if (o == OP_TARGET) begin
			for (int a = 0; a < 3; a++) tgt[a] = p[a];
			phase = 0;
		end else if (o == OP_EFFECT) begin
			for (int a = 0; a < 3; a++) begin
				wp_start[a] = p[a];
				wp_end[a] = e[a];
			end
			phase = 1;
		end
		w.cx = cam[0][31:0];
		w.cy = cam[1][31:0];
		w.cz = cam[2][31:0];
		w.bnc = bnc;
		w.arr = at_target();
		w.ph = phase[2:0];
		return w;
	endfunction

	// input side: predict on accept
	always @(posedge clk) begin
		logic signed [31:0] p[3], e[3];
		cam_word_t w;
		typed_t t;
		if (arst_n && in_valid && in_ready) begin
			p = '{pos_x, pos_y, pos_z};
			e = '{end_x, end_y, end_z};
			w = step_camera(op, elapsed_us, p, e);
			t = typed_q.pop_front();
			cam_q.push_back(t.typed ? t.want : w);
		end
	end

	// output side: compare
	always @(posedge clk) begin
		cam_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (cam_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				w = cam_q.pop_front();
				if (cam_x_out !== w.cx) begin
					$error("cam_x_out exp %h got %h", w.cx, cam_x_out);
					errors++;
				end
				if (cam_y_out !== w.cy) begin
					$error("cam_y_out exp %h got %h", w.cy, cam_y_out);
					errors++;
				end
				if (cam_z_out !== w.cz) begin
					$error("cam_z_out exp %h got %h", w.cz, cam_z_out);
					errors++;
				end
				if (bounced !== w.bnc) begin
					$error("bounced exp %0d got %0d", w.bnc, bounced);
					errors++;
				end
				if (arrived !== w.arr) begin
					$error("arrived exp %0d got %0d", w.arr, arrived);
					errors++;
				end
				if (phase_out !== w.ph) begin
					$error("phase_out exp %0d got %0d", w.ph, phase_out);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCH_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// receiver
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 0;
				out_ready <= 0;
				repeat (400) @(posedge clk);
			end
			if (!calm && $urandom_range(2) == 0) begin
				out_ready <= 0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			out_ready <= 1;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	end

	task automatic send_word(logic [1:0] o, logic [19:0] us,
			logic signed [31:0] p[3], logic signed [31:0] e[3], bit typed, cam_word_t want);
		typed_t t;
		t.typed = typed;
		t.want = want;
		typed_q.push_back(t);
		in_valid <= 1;
		op <= o;
		elapsed_us <= us;
		pos_x <= p[0];
		pos_y <= p[1];
		pos_z <= p[2];
		end_x <= e[0];
		end_y <= e[1];
		end_z <= e[2];
		do @(posedge clk); while (!in_ready);
		if (!calm && $urandom_range(3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_rand(logic [1:0] o, logic [19:0] us,
			logic signed [31:0] p[3], logic signed [31:0] e[3]);
		cam_word_t none;
		send_word(o, us, p, e, 0, none);
	endtask

	task automatic drain();
		in_valid <= 0;
		wait (typed_q.size() == 0 && cam_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_bounds(logic [31:0] b[6]);
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1;
			cfg_idx <= i[2:0];
			cfg_data <= b[i];
			@(posedge clk);
			if (i % 2 == 0) lo_bnd[i / 2] = b[i];
			else hi_bnd[i / 2] = b[i];
		end
		cfg_we <= 0;
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $signed($urandom_range(0, 2 * 1048576)) - 1048576;
			2: return $signed($urandom_range(0, 2 * 400)) - 400;
			3: return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
			default: return $signed($urandom_range(0, 2 * 20000000)) - 20000000;
		endcase
	endfunction

	function automatic logic [19:0] rand_us();
		case ($urandom_range(4))
			0: return '0;
			1: return 20'($urandom_range(1, 200));
			2: return 20'($urandom_range(1000, 40000));
			3: return 20'($urandom_range(500000, 1048575));
			default: return 20'($urandom);
		endcase
	endfunction

	stim_row_t rows[$];
	logic [31:0] bounds[4][6];

	task automatic add_row(logic [1:0] o, logic [19:0] us, logic signed [31:0] p[3],
			logic signed [31:0] e[3], bit typed, cam_word_t want);
		stim_row_t r;
		r.op = o;
		r.us = us;
		r.p = p;
		r.e = e;
		r.typed = typed;
		r.want = want;
		rows.push_back(r);
	endtask

	initial begin
		logic signed [31:0] p[3], e[3];
		cam_word_t w, none;
		int sent, n;
		for (int a = 0; a < 3; a++) begin
			cam[a] = 0;
			tgt[a] = 0;
			wp_start[a] = 0;
			wp_end[a] = 0;
			lo_bnd[a] = BOUND_LO_RST;
			hi_bnd[a] = BOUND_HI_RST;
		end
		phase = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed table
		p = '{0, 0, 0};
		e = '{0, 0, 0};
		w = '{0, 0, 0, 0, 1, 0};
		add_row(OP_TICK, 0, p, e, 1, w);
		p = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0};
		w = '{0, 0, 0, 0, 0, 0};
		add_row(OP_TARGET, 0, p, e, 1, w);
		w = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0, 1, 0};
		add_row(OP_TICK, 0, p, e, 1, w);
		add_row(2'd3, 20'hFFFFF, p, e, 1, w);
		p = '{32'sh0001_0000, -32'sh0003_0000, 32'sh0000_0100};
		add_row(OP_TARGET, 0, p, e, 0, none);
		add_row(OP_TICK, 1, p, e, 0, none);
		add_row(OP_TICK, 16667, p, e, 0, none);
		add_row(OP_TICK, 20'hFFFFF, p, e, 0, none);
		p = '{32'sh0005_0000, 32'sh0002_0000, -32'sh0001_0000};
		e = '{-32'sh0004_0000, 32'sh7FFF_0000, 32'sh8000_0000};
		add_row(OP_EFFECT, 0, p, e, 0, none);
		add_row(OP_TICK, 0, p, e, 0, none);
		add_row(OP_TICK, 16667, p, e, 0, none);
		add_row(OP_TICK, 0, p, e, 0, none);
		add_row(OP_TICK, 500000, p, e, 0, none);
		add_row(OP_TICK, 1000000, p, e, 0, none);
		add_row(OP_TICK, 0, p, e, 0, none);
		add_row(OP_TICK, 33333, p, e, 0, none);
		add_row(OP_TICK, 1000001, p, e, 0, none);
		add_row(OP_TICK, 1000001, p, e, 0, none);
		add_row(OP_EFFECT, 0, p, e, 0, none);
		p = '{32'sh0000_0100, 0, 0};
		add_row(OP_TARGET, 0, p, e, 0, none);
		add_row(OP_TICK, 40000, p, e, 0, none);
		add_row(OP_TICK, 1, p, e, 0, none);
		foreach (rows[i])
			send_word(rows[i].op, rows[i].us, rows[i].p, rows[i].e, rows[i].typed, rows[i].want);
		drain();

		bounds[0] = '{BOUND_LO_RST, BOUND_HI_RST, BOUND_LO_RST, BOUND_HI_RST,
			BOUND_LO_RST, BOUND_HI_RST};
		bounds[1] = '{-32'sd6553600, 32'sd6553600, -32'sd100, 32'sd300, -32'sd65536, 0};
		bounds[2] = '{32'sd1000, -32'sd1000, 32'sd5000000, -32'sd5000000, 0, 0};
		bounds[3] = '{BOUND_HI_RST, BOUND_HI_RST, BOUND_LO_RST, BOUND_LO_RST,
			BOUND_LO_RST, BOUND_HI_RST};

		sent = 0;
		for (int ph = 0; ph < 4; ph++) begin
			set_bounds(bounds[ph]);
			if (ph == 1) hold_req = 1;
			while (sent < 175 * (ph + 1)) begin
				if (ph == 3 && sent > 620) calm = 1;
				case ($urandom_range(9))
					0, 1, 2, 3: begin
						for (int a = 0; a < 3; a++) p[a] = rand_coord();
						send_rand(OP_TARGET, rand_us(), p, e);
						n = $urandom_range(1, 8);
					end
					4, 5, 6, 7: begin
						for (int a = 0; a < 3; a++) begin
							p[a] = rand_coord();
							e[a] = rand_coord();
						end
						send_rand(OP_EFFECT, rand_us(), p, e);
						n = $urandom_range(4, 16);
					end
					8: n = $urandom_range(1, 4);
					default: begin
						for (int a = 0; a < 3; a++) p[a] = $urandom;
						send_rand(2'd3, rand_us(), p, e);
						n = 0;
					end
				endcase
				sent++;
				for (int k = 0; k < n; k++) begin
					for (int a = 0; a < 3; a++) begin
						p[a] = $urandom;
						e[a] = $urandom;
					end
					send_rand(OP_TICK, rand_us(), p, e);
					sent++;
				end
			end
			drain();
		end

		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end

endmodule
